/* src/cdau_pkg.sv */
// Shared constants and month tables for the calendar date arithmetic unit.
package cdau_pkg;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int AMT_W    = 16;
  localparam int SERIAL_W = 22;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_DAYS   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_MONTHS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD_YEARS  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  // Year limits and reset date
  localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;
  localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
  localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;

  // Multiplier constants: floor(x*5243 >> 19) == x/100 for x < 43690,
  // floor(x*43691 >> 19) == x/12 for x < 131072.
  localparam logic [15:0] RECIP_100     = 16'd5243;
  localparam logic [15:0] RECIP_12      = 16'd43691;
  localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
  localparam int          RECIP_SHIFT   = 19;

  // Month length, with leap February
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before month m of a common year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

/* src/calendar_date_arithmetic_unit_top.sv */
// Top level of the calendar date arithmetic unit: sequencer around one shared multiplier.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------------
//  input   | in_valid/in_stall  | in_command, in_load_year, in_load_month, in_load_day,
//          |                    | in_amount
//  result  | out_valid/out_stall| out_year, out_month, out_day, out_date_valid,
//          |                    | out_day_number, out_range_error
//
// One transaction at a time: in_stall is high from acceptance until the result is loaded.
// Each command runs the leap-year pass, then decode. Query and commands refused at decode
// go on to the serial steps; load reruns the leap pass, add years reruns it and fits the
// day, add months splits the month total first. Add days walks month by month; the month
// walk loop steps one month per cycle. A day add past year 1 or 9999 is refused there.
// Synchronous reset sets the date to 2000-01-01 and clears both channels.
// A stalled result holds in the output register; the next command may be accepted then.
module calendar_date_arithmetic_unit_top
  import cdau_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [YEAR_W-1:0]   in_load_year,
  input  logic [MONTH_W-1:0]  in_load_month,
  input  logic [DAY_W-1:0]    in_load_day,
  input  logic signed [AMT_W-1:0] in_amount,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [YEAR_W-1:0]   out_year,
  output logic [MONTH_W-1:0]  out_month,
  output logic [DAY_W-1:0]    out_day,
  output logic                out_date_valid,
  output logic [SERIAL_W-1:0] out_day_number,
  output logic                out_range_error
);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_L0   = 4'd1;   // multiply year by 1/100
  localparam logic [3:0] S_L1   = 4'd2;   // year mod 100 / mod 400
  localparam logic [3:0] S_CMD  = 4'd3;   // decode command
  localparam logic [3:0] S_M1   = 4'd4;   // month total times 1/12
  localparam logic [3:0] S_M2   = 4'd5;   // split into year and month
  localparam logic [3:0] S_WALK = 4'd6;   // day walk, one month per cycle
  localparam logic [3:0] S_FIT  = 4'd7;   // day past month end
  localparam logic [3:0] S_SER0 = 4'd8;   // (y-1)/100
  localparam logic [3:0] S_SER1 = 4'd9;   // (y-1)*365
  localparam logic [3:0] S_SER2 = 4'd10;  // serial sum, result load

  // Where to go after the leap-year pass
  localparam logic [1:0] PH_CMD   = 2'd0;
  localparam logic [1:0] PH_FIT   = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  logic [3:0]               state_r, state_nxt;
  logic [1:0]               phase_r, phase_nxt;
  logic [CMD_W-1:0]         cmd_r, cmd_nxt;
  logic [YEAR_W-1:0]        ly_r, ly_nxt;
  logic [MONTH_W-1:0]       lm_r, lm_nxt;
  logic [DAY_W-1:0]         ld_r, ld_nxt;
  logic signed [AMT_W-1:0]  amt_r, amt_nxt;
  logic                     err_r, err_nxt;
  logic [YEAR_W-1:0]        cur_year_r, cur_year_nxt;
  logic [MONTH_W-1:0]       cur_month_r, cur_month_nxt;
  logic [DAY_W-1:0]         cur_day_r, cur_day_nxt;
  logic [YEAR_W-1:0]        wy_r, wy_nxt;
  logic [MONTH_W-1:0]       wm_r, wm_nxt;
  logic [DAY_W-1:0]         wd_r, wd_nxt;
  logic [6:0]               mod100_r, mod100_nxt;
  logic [8:0]               mod400_r, mod400_nxt;
  logic [32:0]              mul_r, mul_nxt;
  logic [16:0]              t_r, t_nxt;
  logic signed [16:0]       r_r, r_nxt;
  logic [6:0]               kq_r, kq_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]        out_year_r, out_year_nxt;
  logic [MONTH_W-1:0]       out_month_r, out_month_nxt;
  logic [DAY_W-1:0]         out_day_r, out_day_nxt;
  logic                     out_dv_r, out_dv_nxt;
  logic [SERIAL_W-1:0]      out_serial_r, out_serial_nxt;
  logic                     out_err_r, out_err_nxt;

  // Shared multiplier operands
  logic [16:0]              mul_a;
  logic [15:0]              mul_b;
  logic [32:0]              mul_prod;

  // Calendar helpers on the working date
  logic                     leap;
  logic [DAY_W-1:0]         len_cur;
  logic [DAY_W-1:0]         len_prev;
  logic                     wd_ok;
  logic [YEAR_W-1:0]        k;
  logic [6:0]               q100;
  logic [YEAR_W-1:0]        hund;
  logic [YEAR_W-1:0]        diff100;
  logic [8:0]               mod400_calc;
  logic signed [19:0]       t_mon;
  logic                     mon_ok;
  logic signed [17:0]       t_yr;
  logic                     yr_ok;
  logic signed [16:0]       r_init;
  logic                     load_ok;
  logic [YEAR_W-1:0]        qm;
  logic [16:0]              rem12;
  logic [SERIAL_W-1:0]      serial;
  logic                     out_load;
  logic                     in_accept;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_load  = (state_r == S_SER2) && (!out_valid_r || !out_stall);

  // Leap year from the running mod counters
  assign leap     = (wy_r[1:0] == 2'b00) && ((mod100_r != 7'd0) || (mod400_r == 9'd0));
  assign len_cur  = month_days(wm_r, leap);
  assign len_prev = month_days(wm_r - 4'd1, leap);
  assign wd_ok    = (wd_r != 5'd0) && (wd_r <= len_cur);
  assign k        = wy_r - 14'd1;

  // Operand select for the shared multiplier
  always_comb begin
    case (state_r)
      S_L0: begin
        mul_a = {3'b000, wy_r};
        mul_b = RECIP_100;
      end
      S_M1: begin
        mul_a = t_r;
        mul_b = RECIP_12;
      end
      S_SER0: begin
        mul_a = {3'b000, k};
        mul_b = RECIP_100;
      end
      S_SER1: begin
        mul_a = {3'b000, k};
        mul_b = DAYS_PER_YEAR;
      end
      default: begin
        mul_a = 17'd0;
        mul_b = 16'd0;
      end
    endcase
  end
  assign mul_prod = 33'(mul_a) * 33'(mul_b);

  // Year mod 100 and mod 400 from the quotient
  assign q100        = mul_r[RECIP_SHIFT+6:RECIP_SHIFT];
  assign hund        = {7'd0, q100} * 14'd100;
  assign diff100     = wy_r - hund;
  assign mod400_calc = {7'd0, q100[1:0]} * 9'd100 + {2'b00, diff100[6:0]};

  // Command arithmetic
  assign t_mon   = $signed({3'b000, wy_r, 3'b000}) + $signed({4'b0000, wy_r, 2'b00})
                 + $signed({16'd0, wm_r - 4'd1}) + 20'(amt_r);
  assign mon_ok  = (t_mon >= 20'sd12) && (t_mon <= 20'sd119999);
  assign t_yr    = $signed({4'b0000, wy_r}) + 18'(amt_r);
  assign yr_ok   = (t_yr >= 18'sd1) && (t_yr <= 18'sd9999);
  assign r_init  = 17'(amt_r) + $signed({12'd0, wd_r});
  assign load_ok = (ly_r >= YEAR_MIN) && (ly_r <= YEAR_MAX)
                && (lm_r >= MONTH_JAN) && (lm_r <= MONTH_DEC);

  // Month total split: qm = t/12, rem12 = t%12
  assign qm    = mul_r[RECIP_SHIFT+13:RECIP_SHIFT];
  assign rem12 = t_r - {3'b000, qm} * 17'd12;

  // Serial day number of the working date
  assign serial = mul_r[SERIAL_W-1:0]
                + {10'd0, k[YEAR_W-1:2]}
                - {15'd0, kq_r}
                + {17'd0, kq_r[6:2]}
                + {13'd0, days_before(wm_r)}
                + {21'd0, (wm_r > MONTH_FEB) && leap}
                + {17'd0, wd_r};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    cmd_nxt        = cmd_r;
    ly_nxt         = ly_r;
    lm_nxt         = lm_r;
    ld_nxt         = ld_r;
    amt_nxt        = amt_r;
    err_nxt        = err_r;
    cur_year_nxt   = cur_year_r;
    cur_month_nxt  = cur_month_r;
    cur_day_nxt    = cur_day_r;
    wy_nxt         = wy_r;
    wm_nxt         = wm_r;
    wd_nxt         = wd_r;
    mod100_nxt     = mod100_r;
    mod400_nxt     = mod400_r;
    mul_nxt        = mul_r;
    t_nxt          = t_r;
    r_nxt          = r_r;
    kq_nxt         = kq_r;
    out_year_nxt   = out_year_r;
    out_month_nxt  = out_month_r;
    out_day_nxt    = out_day_r;
    out_dv_nxt     = out_dv_r;
    out_serial_nxt = out_serial_r;
    out_err_nxt    = out_err_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt   = in_command;
          ly_nxt    = in_load_year;
          lm_nxt    = in_load_month;
          ld_nxt    = in_load_day;
          amt_nxt   = in_amount;
          err_nxt   = 1'b0;
          wy_nxt    = cur_year_r;
          wm_nxt    = cur_month_r;
          wd_nxt    = cur_day_r;
          phase_nxt = PH_CMD;
          state_nxt = S_L0;
        end
      end

      S_L0: begin
        mul_nxt   = mul_prod;
        state_nxt = S_L1;
      end

      S_L1: begin
        mod100_nxt = diff100[6:0];
        mod400_nxt = mod400_calc;
        case (phase_r)
          PH_CMD:  state_nxt = S_CMD;
          PH_FIT:  state_nxt = S_FIT;
          default: state_nxt = S_SER0;
        endcase
      end

      S_CMD: begin
        state_nxt = S_SER0;
        case (cmd_r)
          CMD_LOAD: begin
            if (load_ok) begin
              wy_nxt    = ly_r;
              wm_nxt    = lm_r;
              wd_nxt    = ld_r;
              phase_nxt = PH_FINAL;
              state_nxt = S_L0;
            end else begin
              err_nxt = 1'b1;
            end
          end
          CMD_ADD_DAYS: begin
            if (wd_ok) begin
              r_nxt     = r_init;
              state_nxt = S_WALK;
            end else begin
              err_nxt = 1'b1;
            end
          end
          CMD_ADD_MONTHS: begin
            if (wd_ok && mon_ok) begin
              t_nxt     = t_mon[16:0];
              state_nxt = S_M1;
            end else begin
              err_nxt = 1'b1;
            end
          end
          CMD_ADD_YEARS: begin
            if (wd_ok && yr_ok) begin
              wy_nxt    = t_yr[YEAR_W-1:0];
              phase_nxt = PH_FIT;
              state_nxt = S_L0;
            end else begin
              err_nxt = 1'b1;
            end
          end
          CMD_QUERY: begin
            err_nxt = 1'b0;
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase
      end

      S_M1: begin
        mul_nxt   = mul_prod;
        state_nxt = S_M2;
      end

      S_M2: begin
        wy_nxt    = qm;
        wm_nxt    = rem12[MONTH_W-1:0] + 4'd1;
        phase_nxt = PH_FIT;
        state_nxt = S_L0;
      end

      // One month boundary per cycle; r is the day within the working month
      S_WALK: begin
        if (r_r > $signed({12'd0, len_cur})) begin
          if (wm_r == MONTH_DEC) begin
            if (wy_r == YEAR_MAX) begin
              err_nxt   = 1'b1;
              wy_nxt    = cur_year_r;
              wm_nxt    = cur_month_r;
              wd_nxt    = cur_day_r;
              phase_nxt = PH_FINAL;
              state_nxt = S_L0;
            end else begin
              wy_nxt     = wy_r + 14'd1;
              wm_nxt     = MONTH_JAN;
              mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
              mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 9'd1;
              r_nxt      = r_r - $signed({12'd0, len_cur});
            end
          end else begin
            wm_nxt = wm_r + 4'd1;
            r_nxt  = r_r - $signed({12'd0, len_cur});
          end
        end else if (r_r < 17'sd1) begin
          if (wm_r == MONTH_JAN) begin
            if (wy_r == YEAR_MIN) begin
              err_nxt   = 1'b1;
              wy_nxt    = cur_year_r;
              wm_nxt    = cur_month_r;
              wd_nxt    = cur_day_r;
              phase_nxt = PH_FINAL;
              state_nxt = S_L0;
            end else begin
              // December is 31 days in any year
              wy_nxt     = wy_r - 14'd1;
              wm_nxt     = MONTH_DEC;
              mod100_nxt = (mod100_r == 7'd0) ? 7'd99 : mod100_r - 7'd1;
              mod400_nxt = (mod400_r == 9'd0) ? 9'd399 : mod400_r - 9'd1;
              r_nxt      = r_r + 17'sd31;
            end
          end else begin
            wm_nxt = wm_r - 4'd1;
            r_nxt  = r_r + $signed({12'd0, len_prev});
          end
        end else begin
          wd_nxt    = r_r[DAY_W-1:0];
          state_nxt = S_SER0;
        end
      end

      // Day past the end of the new month moves to the first of the next
      S_FIT: begin
        if ((wd_r > len_cur) && (wm_r < MONTH_DEC)) begin
          wm_nxt = wm_r + 4'd1;
          wd_nxt = 5'd1;
        end
        state_nxt = S_SER0;
      end

      S_SER0: begin
        mul_nxt   = mul_prod;
        state_nxt = S_SER1;
      end

      S_SER1: begin
        kq_nxt    = q100;
        mul_nxt   = mul_prod;
        state_nxt = S_SER2;
      end

      S_SER2: begin
        if (out_load) begin
          cur_year_nxt   = wy_r;
          cur_month_nxt  = wm_r;
          cur_day_nxt    = wd_r;
          out_year_nxt   = wy_r;
          out_month_nxt  = wm_r;
          out_day_nxt    = wd_r;
          out_dv_nxt     = wd_ok;
          out_serial_nxt = serial;
          out_err_nxt    = err_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and date state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_CMD;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cur_year_r  <= RESET_YEAR;
      cur_month_r <= MONTH_JAN;
      cur_day_r   <= RESET_DAY;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      cur_year_r  <= cur_year_nxt;
      cur_month_r <= cur_month_nxt;
      cur_day_r   <= cur_day_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ly_r         <= ly_nxt;
    lm_r         <= lm_nxt;
    ld_r         <= ld_nxt;
    amt_r        <= amt_nxt;
    wy_r         <= wy_nxt;
    wm_r         <= wm_nxt;
    wd_r         <= wd_nxt;
    mod100_r     <= mod100_nxt;
    mod400_r     <= mod400_nxt;
    mul_r        <= mul_nxt;
    t_r          <= t_nxt;
    r_r          <= r_nxt;
    kq_r         <= kq_nxt;
    out_year_r   <= out_year_nxt;
    out_month_r  <= out_month_nxt;
    out_day_r    <= out_day_nxt;
    out_dv_r     <= out_dv_nxt;
    out_serial_r <= out_serial_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_year        = out_year_r;
  assign out_month       = out_month_r;
  assign out_day         = out_day_r;
  assign out_date_valid  = out_dv_r;
  assign out_day_number  = out_serial_r;
  assign out_range_error = out_err_r;

endmodule

/* src/cdau_checker.sv */
// Port-level assertions for the calendar date arithmetic unit, bound to the top level.
module cdau_checker
  import cdau_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [CMD_W-1:0]    in_command,
  input logic [YEAR_W-1:0]   in_load_year,
  input logic [MONTH_W-1:0]  in_load_month,
  input logic [DAY_W-1:0]    in_load_day,
  input logic signed [AMT_W-1:0] in_amount,
  input logic                out_valid,
  input logic                out_stall,
  input logic [YEAR_W-1:0]   out_year,
  input logic [MONTH_W-1:0]  out_month,
  input logic [DAY_W-1:0]    out_day,
  input logic                out_date_valid,
  input logic [SERIAL_W-1:0] out_day_number,
  input logic                out_range_error
);

  // One transaction in flight: accepting closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction was in flight");

  // Stalled command holds on the input side
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_command) && $stable(in_load_year)
                                && $stable(in_load_month) && $stable(in_load_day)
                                && $stable(in_amount)))
    else $error("stalled command changed");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_year) && $stable(out_month)
                                  && $stable(out_day) && $stable(out_day_number)
                                  && $stable(out_date_valid) && $stable(out_range_error)))
    else $error("stalled result changed");

  // Stored date always stays in the supported range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_year >= YEAR_MIN) && (out_year <= YEAR_MAX)
                   && (out_month >= MONTH_JAN) && (out_month <= MONTH_DEC)))
    else $error("result date out of range");

  // A valid February date never passes day 29
  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_date_valid && (out_month == MONTH_FEB))
      |-> ((out_day != 5'd0) && (out_day <= 5'd29)))
    else $error("valid February date with bad day");

endmodule

bind calendar_date_arithmetic_unit_top cdau_checker u_cdau_checker (.*);

/* sim/tb_calendar_date_arithmetic_unit_top.sv */
// Self-checking testbench for the calendar date arithmetic unit: loads, day/month/year adds, queries.
module tb_calendar_date_arithmetic_unit_top;
  import cdau_pkg::*;

  localparam int N_ITEMS      = 540;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int HOLD_AT_ITEM = 60;
  localparam int DRAIN_CYCLES = 1200;  // worst add-days walk plus margin
  localparam int IDLE_LIMIT   = 8000;  // cycles with no transaction on either channel
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_QUERY + 3'd1;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic [YEAR_W-1:0]       year;
    logic [MONTH_W-1:0]      month;
    logic [DAY_W-1:0]        day;
    logic signed [AMT_W-1:0] amount;
  } date_cmd_t;

  typedef struct {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic                valid;
    logic [SERIAL_W-1:0] day_number;
    logic                refused;
  } date_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_command = CMD_QUERY;
  logic [YEAR_W-1:0] in_load_year = '0;
  logic [MONTH_W-1:0] in_load_month = '0;
  logic [DAY_W-1:0] in_load_day = '0;
  logic signed [AMT_W-1:0] in_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [YEAR_W-1:0] out_year;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0] out_day;
  logic out_date_valid;
  logic [SERIAL_W-1:0] out_day_number;
  logic out_range_error;

  calendar_date_arithmetic_unit_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_load_year(in_load_year), .in_load_month(in_load_month),
    .in_load_day(in_load_day), .in_amount(in_amount),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_year(out_year), .out_month(out_month), .out_day(out_day),
    .out_date_valid(out_date_valid), .out_day_number(out_day_number),
    .out_range_error(out_range_error)
  );

  date_cmd_t    pending_cmds[$];
  date_result_t expected_dates[$];
  date_cmd_t    offered_cmd;

  // Predicted stored date, reset value 2000-01-01
  int cal_year = 2000;
  int cal_month = 1;
  int cal_day = 1;

  int cmds_accepted = 0;
  int dates_checked = 0;
  int refusals_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Calendar arithmetic
  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(int y, int m);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return is_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic int serial_day(int y, int m, int d);
    int k;
    int s;
    k = (y >= 1) ? y - 1 : 0;
    s = k * 365 + k / 4 - k / 100 + k / 400;
    if (m >= 1 && m <= 12)
      for (int i = 1; i < m; i++) s += month_length(y, i);
    return s + d;
  endfunction

  function automatic bit date_fits(int y, int m, int d);
    return y >= 1 && y <= 9999 && d >= 1 && d <= month_length(y, m);
  endfunction

  // Roll a day past the month end to the 1st of the next month
  function automatic void roll_month_end(int y, inout int m, inout int d);
    if (d > month_length(y, m) && m < 12) begin
      m = m + 1;
      d = 1;
    end
  endfunction

  // Apply one command to the predicted date and return the result it reports
  function automatic date_result_t apply_date_cmd(date_cmd_t c);
    date_result_t r;
    int amt;
    int s;
    int t;
    int y;
    int m;
    int d;
    bit refuse;
    amt = int'(c.amount);
    refuse = 1'b0;
    if (c.cmd == CMD_LOAD) begin
      if (c.year >= 1 && c.year <= 9999 && c.month >= 1 && c.month <= 12) begin
        cal_year = int'(c.year);
        cal_month = int'(c.month);
        cal_day = int'(c.day);
      end else refuse = 1'b1;
    end else if (c.cmd == CMD_ADD_DAYS || c.cmd == CMD_ADD_MONTHS || c.cmd == CMD_ADD_YEARS) begin
      if (!date_fits(cal_year, cal_month, cal_day)) begin
        refuse = 1'b1;
      end else if (c.cmd == CMD_ADD_DAYS) begin
        s = serial_day(cal_year, cal_month, cal_day) + amt;
        if (s < 1 || s > serial_day(9999, 12, 31)) begin
          refuse = 1'b1;
        end else begin
          // overestimate the year, walk back through years, then forward through months
          y = s / 365 + 1;
          while (serial_day(y, 1, 1) > s) y--;
          t = s - serial_day(y, 1, 1);
          m = 1;
          while (m < 12 && t >= month_length(y, m)) begin
            t -= month_length(y, m);
            m++;
          end
          cal_year = y;
          cal_month = m;
          cal_day = t + 1;
        end
      end else begin
        if (c.cmd == CMD_ADD_MONTHS) t = cal_year * 12 + cal_month - 1 + amt;
        else t = (cal_year + amt) * 12 + cal_month - 1;
        if (t < 12 || t > 9999 * 12 + 11) begin
          refuse = 1'b1;
        end else begin
          y = t / 12;
          m = t % 12 + 1;
          d = cal_day;
          roll_month_end(y, m, d);
          cal_year = y;
          cal_month = m;
          cal_day = d;
        end
      end
    end else if (c.cmd != CMD_QUERY) begin
      refuse = 1'b1;
    end
    s = serial_day(cal_year, cal_month, cal_day);
    r.year = cal_year[YEAR_W-1:0];
    r.month = cal_month[MONTH_W-1:0];
    r.day = cal_day[DAY_W-1:0];
    r.valid = date_fits(cal_year, cal_month, cal_day);
    r.day_number = s[SERIAL_W-1:0];
    r.refused = refuse;
    return r;
  endfunction

  // Stimulus builders
  function automatic date_cmd_t make_cmd(logic [CMD_W-1:0] cmd, int y, int m, int d, int amt);
    date_cmd_t c;
    c.cmd = cmd;
    c.year = y[YEAR_W-1:0];
    c.month = m[MONTH_W-1:0];
    c.day = d[DAY_W-1:0];
    c.amount = amt[AMT_W-1:0];
    return c;
  endfunction

  function automatic int rand_amount();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Well-formed load: valid date, biased toward month ends and year extremes
  function automatic date_cmd_t rand_load();
    int y;
    int m;
    int d;
    case ($urandom_range(9))
      0:       y = $urandom_range(1, 3);
      1:       y = $urandom_range(9997, 9999);
      default: y = $urandom_range(1, 9999);
    endcase
    m = $urandom_range(1, 12);
    if ($urandom_range(2) == 0) d = $urandom_range(28, month_length(y, m));
    else d = $urandom_range(1, month_length(y, m));
    return make_cmd(CMD_LOAD, y, m, d, rand_amount());
  endfunction

  function automatic date_cmd_t rand_op();
    int amt;
    case ($urandom_range(9))
      0, 1, 2: begin
        case ($urandom_range(2))
          0:       amt = rand_span(40);
          1:       amt = rand_span(1500);
          default: amt = rand_amount();
        endcase
        return make_cmd(CMD_ADD_DAYS, $urandom_range(0, 16383), $urandom_range(0, 15),
                        $urandom_range(0, 31), amt);
      end
      3, 4, 5: begin
        amt = ($urandom_range(3) == 0) ? rand_amount() : rand_span(30);
        return make_cmd(CMD_ADD_MONTHS, $urandom_range(0, 16383), $urandom_range(0, 15),
                        $urandom_range(0, 31), amt);
      end
      6, 7, 8: begin
        amt = ($urandom_range(3) == 0) ? rand_amount() : rand_span(20);
        return make_cmd(CMD_ADD_YEARS, $urandom_range(0, 16383), $urandom_range(0, 15),
                        $urandom_range(0, 31), amt);
      end
      default:
        return make_cmd(CMD_QUERY, $urandom_range(0, 16383), $urandom_range(0, 15),
                        $urandom_range(0, 31), rand_amount());
    endcase
  endfunction

  // Idle rates by phase: receiver-heavy gaps, then sender-heavy, then none
  function automatic int sender_idle_pct();
    if (cmds_accepted < N_ITEMS / 3) return 28;
    if (cmds_accepted < 2 * N_ITEMS / 3) return 76;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (cmds_accepted < N_ITEMS / 3) return 76;
    if (cmds_accepted < 2 * N_ITEMS / 3) return 28;
    return 0;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", dates_checked, what, got, want);
    mismatches++;
  endtask

  // Driver: offer the next pending command, hold it while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_dates.push_back(apply_date_cmd(offered_cmd));
        cmds_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
          offered_cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_command <= offered_cmd.cmd;
          in_load_year <= offered_cmd.year;
          in_load_month <= offered_cmd.month;
          in_load_day <= offered_cmd.day;
          in_amount <= offered_cmd.amount;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction, drive random and long stalls
  always @(posedge clk) begin
    date_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("unexpected transaction, year", longint'(out_year), longint'(0));
        end else begin
          want = expected_dates.pop_front();
          if (out_year !== want.year)
            report_mismatch("year", longint'(out_year), longint'(want.year));
          if (out_month !== want.month)
            report_mismatch("month", longint'(out_month), longint'(want.month));
          if (out_day !== want.day)
            report_mismatch("day", longint'(out_day), longint'(want.day));
          if (out_date_valid !== want.valid)
            report_mismatch("date_valid", longint'(out_date_valid), longint'(want.valid));
          if (out_day_number !== want.day_number)
            report_mismatch("day_number", longint'(out_day_number),
                            longint'(want.day_number));
          if (out_range_error !== want.refused)
            report_mismatch("range_error", longint'(out_range_error),
                            longint'(want.refused));
          if (want.refused) refusals_seen++;
        end
        dates_checked++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && cmds_accepted >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct());
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int y;
    // Directed: extremes, every command, refusals and month-end roll
    pending_cmds.push_back(make_cmd(CMD_QUERY, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 9999, 12, 31, 0));
    pending_cmds.push_back(make_cmd(CMD_ADD_DAYS, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(CMD_ADD_MONTHS, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(CMD_ADD_DAYS, 16383, 15, 31, -32768));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 1, 1, 1, 0));
    pending_cmds.push_back(make_cmd(CMD_ADD_DAYS, 0, 0, 0, -1));
    pending_cmds.push_back(make_cmd(CMD_ADD_MONTHS, 0, 0, 0, -1));
    pending_cmds.push_back(make_cmd(CMD_ADD_YEARS, 0, 0, 0, 32767));
    pending_cmds.push_back(make_cmd(CMD_ADD_DAYS, 0, 0, 0, 32767));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 2000, 1, 31, 0));
    pending_cmds.push_back(make_cmd(CMD_ADD_MONTHS, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 2004, 2, 29, 0));
    pending_cmds.push_back(make_cmd(CMD_ADD_YEARS, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 2001, 2, 29, 0));
    pending_cmds.push_back(make_cmd(CMD_ADD_DAYS, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 2001, 4, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_ADD_YEARS, 0, 0, 0, 1));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 0, 6, 15, 0));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 16383, 6, 15, 0));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 1999, 0, 15, 0));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 1999, 15, 15, 0));
    for (int c = int'(CMD_FIRST_UNUSED); c < 8; c++)
      pending_cmds.push_back(make_cmd(c[CMD_W-1:0], 2024, 2, 29, rand_amount()));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 1900, 12, 31, 0));
    pending_cmds.push_back(make_cmd(CMD_ADD_MONTHS, 0, 0, 0, 2));

    // Random: mostly load-then-operate sequences, some raw noise
    while (pending_cmds.size() < N_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        pending_cmds.push_back(rand_load());
        y = $urandom_range(1, 5);
        for (int i = 0; i < y; i++) pending_cmds.push_back(rand_op());
      end else begin
        pending_cmds.push_back(make_cmd(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 16383),
                                        $urandom_range(0, 15), $urandom_range(0, 31),
                                        rand_amount()));
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands (load, add days/months/years, query, unknown codes),",
             cmds_accepted);
    $display("checked %0d results, %0d of them refused, with stalls on both sides.",
             dates_checked, refusals_seen);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
